// ===== design/open_address_hash_table_core_macros.svh =====
// Assertion macros for the open-address hash table checker.
// Included by the checker file only.
`ifndef OPEN_ADDRESS_HASH_TABLE_CORE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_CORE_MACROS_SVH
// Assert an implication on the rising clock, quiet during reset.
`define OAHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert an implication in the next cycle.
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/oaht_pkg.sv =====
// Package for the open-address hash table: payload structs, codes, widths.
// No dependencies.
`default_nettype none
package oaht_pkg;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SIZE_W          = 11;
    localparam int KEY_W           = 31;
    localparam int SLOT_W          = 10;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 11;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic [SIZE_W-1:0] probe_count;
        logic [1:0]        status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start divider
        logic div_step;  // one restoring division step
        logic div_next;  // latch home, start step division
        logic set_step;  // latch step
        logic rd;        // issue memory read at addr
        logic advance;   // move addr by step
        logic wr;        // write key at addr
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clearing;  // key store still being zeroed after reset
        logic zero_key;
        logic div_done;
        logic hit;       // read data decides
        logic exhausted; // count reached size
        logic is_search;
        logic dbl;
    } sts_t;
endpackage
`default_nettype wire

// ===== design/oaht_ctrl.sv =====
// Controller state machine of the open-address hash table.
// Depends on oaht_pkg.
`default_nettype none
module oaht_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           out_busy,
    output logic                out_load,
    output oaht_pkg::cmd_t      cmd,
    input  wire oaht_pkg::sts_t sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVH = 3'd1;
    localparam logic [2:0] S_DIVS = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;

    // Hold off input until the store clear finishes
    assign in_ready = (state_reg == S_IDLE) && !sts.clearing;

    // One request: one or two divisions, then read/check probes
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !sts.clearing)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIVH;
                end
            end
            S_DIVH:
            begin
                if (sts.zero_key)
                    state_next = S_DONE;
                else if (sts.div_done)
                begin
                    cmd.div_next = 1'b1;
                    state_next   = sts.dbl ? S_DIVS : S_RD;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_DIVS:
            begin
                if (sts.div_done)
                begin
                    cmd.set_step = 1'b1;
                    state_next   = S_RD;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.hit)
                begin
                    cmd.wr     = !sts.is_search;
                    state_next = S_DONE;
                end
                else if (sts.exhausted)
                    state_next = S_DONE;
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== design/oaht_dp.sv =====
// Datapath of the open-address hash table: divider, probe address, key store.
// Depends on oaht_pkg.
`default_nettype none
module oaht_dp #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire oaht_pkg::req_t              req,
    input  wire logic                        cfg_we,
    input  wire logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [oaht_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire oaht_pkg::cmd_t              cmd,
    output oaht_pkg::sts_t                   sts,
    output oaht_pkg::rsp_t                   rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NW > oaht_pkg::SIZE_W) ? NW : oaht_pkg::SIZE_W;
    localparam int KW = oaht_pkg::KEY_W;
    localparam int DW = KW;
    localparam int BW = $clog2(DW + 1);

    // Configuration registers
    logic [oaht_pkg::SIZE_W-1:0] size_cfg_reg;
    logic                        mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= oaht_pkg::SIZE_W'(1024);
            mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                oaht_pkg::REG_TABLE_SIZE: size_cfg_reg <= cfg_data;
                oaht_pkg::REG_PROBE_MODE: mode_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp size into 3..TABLE_DEPTH
    logic [CW-1:0] size_w, n_eff;
    assign size_w = CW'(size_cfg_reg);
    always_comb
    begin
        if (size_w < CW'(3))
            n_eff = CW'(3);
        else if (size_w > CW'(TABLE_DEPTH))
            n_eff = CW'(TABLE_DEPTH);
        else
            n_eff = size_w;
    end

    // Request capture
    logic [DW-1:0] key_reg;
    logic          search_reg;
    logic          dbl_reg;
    logic [CW-1:0] n_reg;

    // Restoring divider: remainder of key by divisor, one bit a step
    logic [DW-1:0] quo_reg;
    logic [CW:0]   rem_reg;
    logic [CW-1:0] dvs_reg;
    logic [BW-1:0] cnt_reg;
    logic [CW:0]   rem_sh, rem_sub;

    assign rem_sh  = {rem_reg[CW-1:0], quo_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // Probe state
    logic [AW-1:0] addr_reg;
    logic [CW-1:0] step_reg;
    logic [CW-1:0] count_reg;
    logic [CW:0]   addr_sum;
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] mem [TABLE_DEPTH];
    logic          rsp_first_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_busy_reg;

    assign addr_sum = {1'b0, CW'(addr_reg)} + {1'b0, step_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= DW'(req.key);
            search_reg <= req.req_type;
            dbl_reg    <= mode_reg;
            n_reg      <= n_eff;
            quo_reg    <= DW'(req.key);
            rem_reg    <= '0;
            dvs_reg    <= n_eff;
            cnt_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DW-2:0], 1'b0};
            cnt_reg <= cnt_reg + BW'(1);
            if (!rem_sub[CW])
                rem_reg <= rem_sub;
            else
                rem_reg <= rem_sh;
        end
        else if (cmd.div_next)
        begin
            addr_reg  <= AW'(rem_reg);
            count_reg <= CW'(1);
            step_reg  <= CW'(1);
            quo_reg   <= key_reg;
            rem_reg   <= '0;
            dvs_reg   <= n_reg - CW'(2);
            cnt_reg   <= '0;
        end
        else if (cmd.set_step)
            step_reg <= CW'(rem_reg) + CW'(1);
        else if (cmd.advance)
        begin
            if (addr_sum >= {1'b0, n_reg})
                addr_reg <= AW'(addr_sum - {1'b0, n_reg});
            else
                addr_reg <= AW'(addr_sum);
            if (rsp_first_reg)
                count_reg <= CW'(1);
            else
                count_reg <= count_reg + CW'(1);
        end
    end

    // first advance keeps count at 1; later ones add one
    always_ff @(posedge clk)
    begin
        if (cmd.div_next)
            rsp_first_reg <= 1'b1;
        else if (cmd.advance)
            rsp_first_reg <= 1'b0;
    end

    // Sweep the store once after reset, one slot a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // Key store: clear pass first, then request writes
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (cmd.wr)
            mem[addr_reg] <= key_reg;
        if (cmd.rd)
            rd_data_reg <= mem[addr_reg];
    end

    logic empty, match;
    assign empty = (rd_data_reg == '0);
    assign match = (rd_data_reg == key_reg);

    // Status out
    assign sts.clearing  = clr_busy_reg;
    assign sts.zero_key  = (key_reg == '0);
    assign sts.div_done  = (cnt_reg == BW'(DW));
    assign sts.hit       = empty || (search_reg && match);
    assign sts.exhausted = !rsp_first_reg && (count_reg == n_reg)
                           || (rsp_first_reg && n_reg == CW'(0));
    assign sts.is_search = search_reg;
    assign sts.dbl       = dbl_reg;

    // Result word
    always_comb
    begin
        if (sts.zero_key)
        begin
            rsp.slot        = '0;
            rsp.found       = 1'b0;
            rsp.probe_count = '0;
            rsp.status      = oaht_pkg::ST_ZERO;
        end
        else
        begin
            rsp.slot        = oaht_pkg::SLOT_W'(addr_reg);
            rsp.found       = sts.hit && search_reg && !empty;
            rsp.probe_count = oaht_pkg::SIZE_W'(count_reg);
            rsp.status      = sts.hit ? oaht_pkg::ST_OK : oaht_pkg::ST_FULL;
        end
    end
endmodule
`default_nettype wire

// ===== design/open_address_hash_table_core.sv =====
// Top level of the open-address hash table: controller, datapath, output register.
// Depends on oaht_pkg, oaht_ctrl, oaht_dp.
//
//  channel | signals                         | word
//  in      | in_valid, in_ready, in_data     | req_t
//  out     | out_valid, out_ready, out_data  | rsp_t
//  cfg     | cfg_we, cfg_idx, cfg_data       | table_size / probe_mode
//
// An item is taken, then a bit-serial remainder is formed (two remainders in double
// hashing, one in linear), then each slot is probed with a read and a check through
// the key memory port, and the result is loaded. One item at a time.
// Reset starts a clear pass over all TABLE_DEPTH slots that zeroes the key store; no
// word is taken until it ends. A finished result waits in the output register;
// the next item is taken meanwhile, and a second result waits until it drains.
`default_nettype none
module open_address_hash_table_core #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire oaht_pkg::req_t                  in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output oaht_pkg::rsp_t                       out_data,
    input  wire logic                            cfg_we,
    input  wire logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [oaht_pkg::CFG_DATA_W-1:0] cfg_data
);
    oaht_pkg::cmd_t cmd;
    oaht_pkg::sts_t sts;
    oaht_pkg::rsp_t rsp;
    logic           out_load;
    logic           out_valid_reg;
    oaht_pkg::rsp_t out_data_reg;

    oaht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_busy (out_valid_reg && !out_ready),
        .out_load (out_load),
        .cmd      (cmd),
        .sts      (sts)
    );

    oaht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (in_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= rsp;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule
`default_nettype wire

// ===== design/oaht_checker.sv =====
// Port-level checker for the open-address hash table, bound to the top level.
// Depends on oaht_pkg and the assertion macro header.
`default_nettype none
`include "open_address_hash_table_core_macros.svh"
module oaht_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire oaht_pkg::req_t in_data,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire oaht_pkg::rsp_t out_data
);
    // Hold output word while stalled
    `OAHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_data), "output word changed while stalled")
    // Hold input word while it waits
    `OAHT_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(in_data), "input word changed while waiting")
    // Accepting an item makes the block busy next cycle
    `OAHT_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "input taken twice in a row")
    // Status code is always defined
    `OAHT_ASSERT_IMP(a_status, out_valid, out_data.status <= oaht_pkg::ST_ZERO,
        "bad status code")
    // Zero-key result carries no found flag and no count
    `OAHT_ASSERT_IMP(a_zero, out_valid && out_data.status == oaht_pkg::ST_ZERO,
        !out_data.found && out_data.probe_count == '0, "zero-key result not cleared")
endmodule
bind open_address_hash_table_core oaht_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
